// ===== rtl/mpid_pkg.sv =====
package mpid_pkg;

    // Default sizes of the residue datapath and of the exponent.
    localparam int DEF_MOD_WIDTH = 32;
    localparam int DEF_EXP_WIDTH = 63;

    // Fixed field widths and positions on the stream ports.
    localparam int BASE_W    = 32;
    localparam int EXPF_W    = 63;
    localparam int DIV_W     = 32;
    localparam int BASE_LSB  = 0;
    localparam int EXP_LSB   = BASE_LSB + BASE_W;
    localparam int DIV_LSB   = EXP_LSB + EXPF_W;
    localparam int IN_DATA_W = ((DIV_LSB + DIV_W + 7) / 8) * 8;
    localparam int RES_W     = 32;
    localparam int OP_W      = 2;

    localparam logic [31:0] RESET_MODULUS = 32'd1000000007;
    localparam int          MIN_MODULUS   = 2;

    // Operation selector codes.
    localparam logic [OP_W-1:0] OP_POWER   = 2'd0;
    localparam logic [OP_W-1:0] OP_INVERSE = 2'd1;
    localparam logic [OP_W-1:0] OP_DIVIDE  = 2'd2;

    // Microprogram addresses.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_FETCH  = 4'd0;
    localparam step_t ST_CHECK  = 4'd1;
    localparam step_t ST_ISDIV  = 4'd2;
    localparam step_t ST_BMRED  = 4'd3;
    localparam step_t ST_SQINIT = 4'd4;
    localparam step_t ST_LOOP   = 4'd5;
    localparam step_t ST_ODD    = 4'd6;
    localparam step_t ST_MULACC = 4'd7;
    localparam step_t ST_SQUARE = 4'd8;
    localparam step_t ST_FINAL  = 4'd9;
    localparam step_t ST_DIVMUL = 4'd10;
    localparam step_t ST_EMIT   = 4'd11;
    localparam step_t ST_ZERO   = 4'd12;

    typedef enum logic [1:0] {X_ONE, X_ACC, X_SQ, X_BM} xsel_t;
    typedef enum logic [1:0] {Y_BASE, Y_OPND, Y_ACC, Y_SQ} ysel_t;
    typedef enum logic [1:0] {D_NONE, D_SQ, D_ACC, D_BM} dst_t;
    typedef enum logic [2:0] {
        C_NEVER, C_ALWAYS, C_NOT_VALID, C_BAD, C_NOT_DIV, C_EZERO, C_EEVEN
    } cond_t;
    typedef enum logic [1:0] {O_NONE, O_ACC, O_ZERO} outsel_t;

    typedef struct packed {
        logic    mul;
        xsel_t   xsel;
        ysel_t   ysel;
        dst_t    dst;
        logic    eshift;
        cond_t   cond;
        step_t   target;
        outsel_t outsel;
    } ctrl_t;

    // The microprogram: one control word per step.
    function automatic ctrl_t step_rom(step_t s);
        ctrl_t w;
        w = '{mul: 1'b0, xsel: X_ONE, ysel: Y_BASE, dst: D_NONE, eshift: 1'b0,
              cond: C_NEVER, target: ST_FETCH, outsel: O_NONE};
        case (s)
            ST_FETCH:
            begin
                w.cond   = C_NOT_VALID;
                w.target = ST_FETCH;
            end
            ST_CHECK:
            begin
                w.cond   = C_BAD;
                w.target = ST_ZERO;
            end
            ST_ISDIV:
            begin
                w.cond   = C_NOT_DIV;
                w.target = ST_SQINIT;
            end
            ST_BMRED:
            begin
                w.mul  = 1'b1;
                w.xsel = X_ONE;
                w.ysel = Y_BASE;
                w.dst  = D_BM;
            end
            ST_SQINIT:
            begin
                w.mul  = 1'b1;
                w.xsel = X_ONE;
                w.ysel = Y_OPND;
                w.dst  = D_SQ;
            end
            ST_LOOP:
            begin
                w.cond   = C_EZERO;
                w.target = ST_FINAL;
            end
            ST_ODD:
            begin
                w.cond   = C_EEVEN;
                w.target = ST_SQUARE;
            end
            ST_MULACC:
            begin
                w.mul  = 1'b1;
                w.xsel = X_ACC;
                w.ysel = Y_SQ;
                w.dst  = D_ACC;
            end
            ST_SQUARE:
            begin
                w.mul    = 1'b1;
                w.xsel   = X_SQ;
                w.ysel   = Y_SQ;
                w.dst    = D_SQ;
                w.eshift = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = ST_LOOP;
            end
            ST_FINAL:
            begin
                w.cond   = C_NOT_DIV;
                w.target = ST_EMIT;
            end
            ST_DIVMUL:
            begin
                w.mul  = 1'b1;
                w.xsel = X_BM;
                w.ysel = Y_ACC;
                w.dst  = D_ACC;
            end
            ST_EMIT:
            begin
                w.outsel = O_ACC;
                w.cond   = C_ALWAYS;
                w.target = ST_FETCH;
            end
            ST_ZERO:
            begin
                w.outsel = O_ZERO;
                w.cond   = C_ALWAYS;
                w.target = ST_FETCH;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/modular_power_inverse_divide.sv =====
// Modular power, Fermat inverse and modular division over a configured modulus.
//
// Requests arrive on the s_ channel as one word each: s_tuser carries the
// operation (power, inverse, divide) and s_tdata the base, exponent and divisor.
// Each request gives exactly one residue word on the m_ channel. The modulus is
// written through cfg_we / cfg_wdata; the user must do so only while the block
// is idle, which the block itself does not enforce. After reset it is 1000000007.
//
// Reset clears the sequencer and drops any pending result. One request is
// processed at a time. Each modular product runs on a shared bit-serial
// multiplier. The exponent (the exponent for power, modulus - 2 otherwise) is
// scanned from its low bit: each bit costs a squaring and each one bit a
// further product into the accumulator. A divide request raises the divisor
// instead and multiplies the result by the base, reduced first, at the end; a
// modulus below two or an unused selector gives a zero residue with no products.
// The finished residue sits in an output register, so s_tready comes back as
// soon as the result is written, even while m_tready is low; a stalled result
// blocks only the next write of the output register.
module modular_power_inverse_divide
    import mpid_pkg::*;
#(
    parameter int MOD_WIDTH = DEF_MOD_WIDTH,
    parameter int EXP_WIDTH = DEF_EXP_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata fields from bit 0 up: base[31:0], exponent[62:0], divisor[31:0], pad
    input  logic [IN_DATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0 up: req_type[1:0]
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata fields from bit 0 up: residue[31:0]
    output logic [RES_W-1:0]     m_tdata,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata
);

    // The exponent register must also hold modulus - 2.
    localparam int EXR_W = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
    localparam int CNT_W = $clog2(MOD_WIDTH);
    localparam int T_W   = MOD_WIDTH + 2;

    // Configuration and sequencer state.
    logic [MOD_WIDTH-1:0] modulus_reg;
    step_t                step_reg;
    step_t                step_next;
    logic [OP_W-1:0]      op_reg;

    // Operand and working registers.
    logic [MOD_WIDTH-1:0] opb_reg;
    logic [MOD_WIDTH-1:0] opd_reg;
    logic [EXR_W-1:0]     exp_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] sq_reg;
    logic [MOD_WIDTH-1:0] bm_reg;

    // Bit-serial modular multiplier.
    logic                 mbusy_reg;
    logic [CNT_W-1:0]     mcnt_reg;
    logic [MOD_WIDTH-1:0] mx_reg;
    logic [MOD_WIDTH-1:0] my_reg;
    logic [MOD_WIDTH-1:0] mr_reg;
    logic [MOD_WIDTH-1:0] mr_next;

    // Output register.
    logic                 out_valid_reg;
    logic [MOD_WIDTH-1:0] out_data_reg;

    ctrl_t                ctrl;
    logic                 accept;
    logic                 mul_last;
    logic                 out_free;
    logic                 step_done;
    logic                 cond_true;
    logic                 bad_req;
    logic [MOD_WIDTH-1:0] xval;
    logic [MOD_WIDTH-1:0] yval;
    logic [T_W-1:0]       t_sum;
    logic [T_W-1:0]       m_one;
    logic [T_W-1:0]       m_two;
    logic [T_W-1:0]       t_red;

    assign ctrl     = step_rom(step_reg);
    assign s_tready = (step_reg == ST_FETCH);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = RES_W'(out_data_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign mul_last = mbusy_reg && (mcnt_reg == CNT_W'(MOD_WIDTH - 1));

    // A modulus below two, or an unused selector, gives a zero residue.
    assign bad_req = (modulus_reg < MOD_WIDTH'(MIN_MODULUS)) ||
                     !((op_reg == OP_POWER) || (op_reg == OP_INVERSE) ||
                       (op_reg == OP_DIVIDE));

    // One step of the interleaved product: r = 2r + x * (top bit of y), then
    // reduced from below 3m back below m.
    always_comb
    begin
        m_one = T_W'(modulus_reg);
        m_two = {1'b0, modulus_reg, 1'b0};
        t_sum = {1'b0, mr_reg, 1'b0} + (my_reg[MOD_WIDTH-1] ? T_W'(mx_reg) : '0);
        if (t_sum >= m_two)
        begin
            t_red = t_sum - m_two;
        end
        else if (t_sum >= m_one)
        begin
            t_red = t_sum - m_one;
        end
        else
        begin
            t_red = t_sum;
        end
        mr_next = t_red[MOD_WIDTH-1:0];
    end

    // Operand selection for the multiplier. x must already be below the modulus;
    // y is scanned bit by bit, so it may be any value.
    always_comb
    begin
        case (ctrl.xsel)
            X_ONE:   xval = MOD_WIDTH'(1);
            X_ACC:   xval = acc_reg;
            X_SQ:    xval = sq_reg;
            X_BM:    xval = bm_reg;
            default: xval = '0;
        endcase
        case (ctrl.ysel)
            Y_BASE:  yval = opb_reg;
            Y_OPND:  yval = (op_reg == OP_DIVIDE) ? opd_reg : opb_reg;
            Y_ACC:   yval = acc_reg;
            Y_SQ:    yval = sq_reg;
            default: yval = '0;
        endcase
    end

    // Step completion, branch condition and next step.
    always_comb
    begin
        if (ctrl.mul)
        begin
            step_done = mul_last;
        end
        else if (ctrl.outsel != O_NONE)
        begin
            step_done = out_free;
        end
        else
        begin
            step_done = 1'b1;
        end

        case (ctrl.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NOT_VALID: cond_true = !s_tvalid;
            C_BAD:       cond_true = bad_req;
            C_NOT_DIV:   cond_true = (op_reg != OP_DIVIDE);
            C_EZERO:     cond_true = (exp_reg == '0);
            C_EEVEN:     cond_true = !exp_reg[0];
            default:     cond_true = 1'b0;
        endcase

        if (!step_done)
        begin
            step_next = step_reg;
        end
        else if (cond_true)
        begin
            step_next = ctrl.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= RESET_MODULUS[MOD_WIDTH-1:0];
            step_reg      <= ST_FETCH;
            mbusy_reg     <= 1'b0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata[MOD_WIDTH-1:0];
            end

            step_reg <= step_next;

            if (ctrl.mul && !mbusy_reg)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg + CNT_W'(1);
                if (mul_last)
                begin
                    mbusy_reg <= 1'b0;
                end
            end

            if (step_done && (ctrl.outsel != O_NONE))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser;
            opb_reg <= s_tdata[BASE_LSB +: MOD_WIDTH];
            opd_reg <= s_tdata[DIV_LSB +: MOD_WIDTH];
            acc_reg <= MOD_WIDTH'(1);
            if (s_tuser == OP_POWER)
            begin
                exp_reg <= EXR_W'(s_tdata[EXP_LSB +: EXP_WIDTH]);
            end
            else
            begin
                exp_reg <= EXR_W'(modulus_reg - MOD_WIDTH'(MIN_MODULUS));
            end
        end
        else
        begin
            if (step_done && ctrl.eshift)
            begin
                exp_reg <= exp_reg >> 1;
            end
            if (mul_last)
            begin
                case (ctrl.dst)
                    D_SQ:    sq_reg  <= mr_next;
                    D_ACC:   acc_reg <= mr_next;
                    D_BM:    bm_reg  <= mr_next;
                    default: ;
                endcase
            end
        end

        if (ctrl.mul && !mbusy_reg)
        begin
            mx_reg <= xval;
            my_reg <= yval;
            mr_reg <= '0;
        end
        else if (mbusy_reg)
        begin
            mr_reg <= mr_next;
            my_reg <= my_reg << 1;
        end

        if (step_done && (ctrl.outsel == O_ACC))
        begin
            out_data_reg <= acc_reg;
        end
        else if (step_done && (ctrl.outsel == O_ZERO))
        begin
            out_data_reg <= '0;
        end
    end

endmodule

// ===== rtl/mpid_checker.sv =====
module mpid_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // Requests are taken one at a time: after a word is accepted the input closes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in work");

    // A new result appears only as a request finishes, which reopens the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> (s_tready && !$past(s_tready)))
        else $error("result produced outside the end of a request");

endmodule

bind modular_power_inverse_divide mpid_checker u_mpid_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
